// ===== src/rolling_hash_substring_matcher_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the rolling hash substring matcher
// Concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ROLLING_HASH_SUBSTRING_MATCHER_ASSERT_SVH
`define ROLLING_HASH_SUBSTRING_MATCHER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Check that a condition holds at every clock edge
`define RHSM_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a consequent holds in the cycle of its antecedent
`define RHSM_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`else

`define RHSM_ASSERT_ALWAYS(lbl, cond, msg)
`define RHSM_ASSERT_IMPLY(lbl, ante, cons, msg)

`endif

`endif

// ===== src/rhsm_pkg.sv =====
// ----------------------------------------------------------------------------
// rhsm_pkg
// Types, constants and modular helpers of the rolling hash substring matcher.
// ----------------------------------------------------------------------------
package rhsm_pkg;

  // Hash arithmetic: base 26 modulo 1e9+7
  localparam int HashW = 30;
  localparam logic [HashW-1:0] HashMod = 30'd1000000007;

  // Multiplier operand of the serial multiply unit
  localparam int KW = 8;
  localparam logic [KW-1:0] HashBase = 8'd26;

  // Code of the letter a
  localparam logic [7:0] CharOffset = 8'd97;

  typedef logic [HashW-1:0] hash_t;

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_PATTERN = 2'd1,
    ACT_RESTART = 2'd2,
    ACT_TEXT    = 2'd3
  } action_e;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_DROP  = 6'b000010,
    S_TPUSH = 6'b000100,
    S_PPUSH = 6'b001000,
    S_POWER = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  // Shift enables for the row of cells
  typedef struct packed {
    logic shift_pat;
    logic shift_win;
  } cell_ctrl_t;

  // (a + b) mod M for a, b below M
  function automatic hash_t add_mod(hash_t a, hash_t b);
    logic [HashW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, HashMod}) begin
      s = s - {1'b0, HashMod};
    end
    return s[HashW-1:0];
  endfunction

  // (a - b) mod M for a, b below M
  function automatic hash_t sub_mod(hash_t a, hash_t b);
    hash_t r;
    if (a >= b) begin
      r = a - b;
    end else begin
      r = a + (HashMod - b);
    end
    return r;
  endfunction

  // (2 * a) mod M for a below M
  function automatic hash_t dbl_mod(hash_t a);
    logic [HashW:0] s;
    s = {a, 1'b0};
    if (s >= {1'b0, HashMod}) begin
      s = s - {1'b0, HashMod};
    end
    return s[HashW-1:0];
  endfunction

  // Digit of a character: (c - 97) mod M
  function automatic hash_t digit_of(logic [7:0] c);
    hash_t r;
    if (c >= CharOffset) begin
      r = hash_t'(c - CharOffset);
    end else begin
      r = HashMod - hash_t'(CharOffset - c);
    end
    return r;
  endfunction

  // Magnitude of the signed offset c - 97
  function automatic logic [KW-1:0] char_mag(logic [7:0] c);
    logic [KW-1:0] r;
    if (c >= CharOffset) begin
      r = c - CharOffset;
    end else begin
      r = CharOffset - c;
    end
    return r;
  endfunction

endpackage

// ===== src/rhsm_cell.sv =====
// ----------------------------------------------------------------------------
// rhsm_cell
// One position of the pattern and text window rows, with its own compare.
// ----------------------------------------------------------------------------
module rhsm_cell (
  input  logic                clk_i,
  input  rhsm_pkg::cell_ctrl_t ctrl_i,
  input  logic [7:0]          pat_i,
  input  logic [7:0]          win_i,
  input  logic                active_i,
  output logic [7:0]          pat_o,
  output logic [7:0]          win_o,
  output logic                hit_o
);

  logic [7:0] pat_q;
  logic [7:0] win_q;

  // Shift pattern and window characters toward older positions
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_pat) begin
      pat_q <= pat_i;
    end
    if (ctrl_i.shift_win) begin
      win_q <= win_i;
    end
  end

  assign pat_o = pat_q;
  assign win_o = win_q;

  // Positions past the pattern end always agree
  assign hit_o = !active_i || (pat_q == win_q);

endmodule

// ===== src/rhsm_mulmod.sv =====
// ----------------------------------------------------------------------------
// rhsm_mulmod
// Serial modular multiply a * k mod M, one bit of k per cycle, MSB first.
// ----------------------------------------------------------------------------
module rhsm_mulmod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  rhsm_pkg::hash_t           a_i,
  input  logic [rhsm_pkg::KW-1:0]   k_i,
  output logic                      done_o,
  output rhsm_pkg::hash_t           r_o
);

  localparam int CntW = $clog2(rhsm_pkg::KW);
  localparam logic [CntW-1:0] CntLast = CntW'(rhsm_pkg::KW - 1);

  logic                    busy_q;
  logic                    done_q;
  logic [CntW-1:0]         cnt_q;
  rhsm_pkg::hash_t         a_q;
  logic [rhsm_pkg::KW-1:0] k_q;
  rhsm_pkg::hash_t         r_q;
  rhsm_pkg::hash_t         r_d;

  // Double the partial result, then add a when the current bit is set
  always_comb begin
    r_d = rhsm_pkg::dbl_mod(r_q);
    if (k_q[rhsm_pkg::KW-1]) begin
      r_d = rhsm_pkg::add_mod(r_d, a_q);
    end
  end

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          busy_q <= 1'b0;
        end
      end
      // Flag the last step for one cycle
      done_q <= !start_i && busy_q && (cnt_q == CntLast);
    end
  end

  // Operands and partial result
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      k_q <= k_i;
      r_q <= '0;
    end else if (busy_q) begin
      k_q <= {k_q[rhsm_pkg::KW-2:0], 1'b0};
      r_q <= r_d;
    end
  end

  assign done_o = done_q;
  assign r_o    = r_q;

endmodule

// ===== src/rolling_hash_substring_matcher.sv =====
// ----------------------------------------------------------------------------
// rolling_hash_substring_matcher
// Rabin-Karp matcher: pattern and text window live in a row of cells, the
// base 26 hashes modulo 1e9+7 go through one shared serial multiply unit.
// ----------------------------------------------------------------------------
//
//  channel  direction  tdata                 tuser
//  s_axis   in         [7:0] char_code       [1:0] action
//  m_axis   out        [31:0] match_start    [0] match
//
//  Steps per item (one item at a time, the multiply unit sets the pace):
//    clear, restart: register updates only. Pattern append: hash step, then,
//    from the second character on, the leading power step.
//    Text character: no hash step with an empty pattern, the push while the
//    window fills, once full the drop of the oldest digit, then the push.
//  Reset clears control and hash state at once; the cell rows are not cleared
//  and are only compared once written. A result waits in the output register
//  while the next item is taken; only a second result waiting on a stalled
//  output holds the block.
//
module rolling_hash_substring_matcher #(
  parameter int MAX_PATTERN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] match_start
  output logic        m_axis_tuser    // [0] match
);

  `include "rolling_hash_substring_matcher_assert.svh"

  localparam int LenW = $clog2(MAX_PATTERN + 1);
  localparam int IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_PATTERN);

  rhsm_pkg::state_e    state_q;
  logic [LenW-1:0]     plen_q;
  rhsm_pkg::hash_t     ph_q;
  rhsm_pkg::hash_t     lp_q;
  rhsm_pkg::hash_t     wh_q;
  logic [LenW-1:0]     filled_q;
  logic [31:0]         tp_q;
  logic [7:0]          c_q;
  logic [7:0]          old_q;
  logic                out_valid_q;
  logic                out_match_q;
  logic [31:0]         out_start_q;

  logic                accept;
  rhsm_pkg::action_e   act;
  logic                n_zero;
  logic                win_full;
  logic                pat_full;
  logic [IdxW-1:0]     tail_idx;
  logic [7:0]          tail_char;
  logic                out_load;
  logic                hit;
  logic [31:0]         start_pos;
  rhsm_pkg::hash_t     drop;
  rhsm_pkg::hash_t     h_after_drop;
  rhsm_pkg::hash_t     pushed;

  logic                    mm_start;
  rhsm_pkg::hash_t         mm_a;
  logic [rhsm_pkg::KW-1:0] mm_k;
  logic                    mm_done;
  rhsm_pkg::hash_t         mm_r;

  rhsm_pkg::cell_ctrl_t cell_ctrl;
  logic [7:0]           pat_chain [MAX_PATTERN];
  logic [7:0]           win_chain [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] cell_hit;

  // Input handshake and decode
  assign s_axis_tready = (state_q == rhsm_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign act           = rhsm_pkg::action_e'(s_axis_tuser);
  assign n_zero        = (plen_q == '0);
  assign win_full      = (filled_q >= plen_q);
  assign pat_full      = (plen_q == MaxLen);

  // Oldest window character sits at position n-1
  assign tail_idx  = IdxW'(plen_q - 1'b1);
  assign tail_char = win_chain[tail_idx];

  // Row of cells
  assign cell_ctrl.shift_pat = accept && (act == rhsm_pkg::ACT_PATTERN) && !pat_full;
  assign cell_ctrl.shift_win = accept && (act == rhsm_pkg::ACT_TEXT) && !n_zero;

  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic [7:0] pat_in;
    logic [7:0] win_in;
    if (j == 0) begin : g_head
      assign pat_in = s_axis_tdata;
      assign win_in = s_axis_tdata;
    end else begin : g_link
      assign pat_in = pat_chain[j-1];
      assign win_in = win_chain[j-1];
    end
    rhsm_cell u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (cell_ctrl),
      .pat_i    (pat_in),
      .win_i    (win_in),
      .active_i (LenW'(j) < plen_q),
      .pat_o    (pat_chain[j]),
      .win_o    (win_chain[j]),
      .hit_o    (cell_hit[j])
    );
  end

  // Hash steps around the multiply unit
  always_comb begin
    // digit of the dropped character is negative below a
    if ((old_q >= rhsm_pkg::CharOffset) || (mm_r == '0)) begin
      drop = mm_r;
    end else begin
      drop = rhsm_pkg::HashMod - mm_r;
    end
    h_after_drop = rhsm_pkg::sub_mod(wh_q, drop);
    pushed       = rhsm_pkg::add_mod(mm_r, rhsm_pkg::digit_of(c_q));
  end

  // Launch the multiply unit
  always_comb begin
    mm_start = 1'b0;
    mm_a     = wh_q;
    mm_k     = rhsm_pkg::HashBase;
    unique case (state_q)
      rhsm_pkg::S_IDLE: begin
        if (accept && (act == rhsm_pkg::ACT_TEXT) && !n_zero) begin
          mm_start = 1'b1;
          if (win_full) begin
            mm_a = lp_q;
            mm_k = rhsm_pkg::char_mag(tail_char);
          end
        end else if (accept && (act == rhsm_pkg::ACT_PATTERN) && !pat_full) begin
          mm_start = 1'b1;
          mm_a     = ph_q;
        end
      end
      rhsm_pkg::S_DROP: begin
        mm_start = mm_done;
        mm_a     = h_after_drop;
      end
      rhsm_pkg::S_PPUSH: begin
        mm_start = mm_done && (plen_q > LenW'(1));
        mm_a     = lp_q;
      end
      rhsm_pkg::S_TPUSH, rhsm_pkg::S_POWER, rhsm_pkg::S_DONE: begin
        mm_start = 1'b0;
      end
      default: begin
        mm_start = 1'b0;
      end
    endcase
  end

  rhsm_mulmod u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .a_i     (mm_a),
    .k_i     (mm_k),
    .done_o  (mm_done),
    .r_o     (mm_r)
  );

  // Match decision on the updated window
  assign hit = (filled_q == plen_q) && (wh_q == ph_q) && (&cell_hit);
  assign start_pos = n_zero ? tp_q : (tp_q + 32'd1 - 32'(plen_q));
  assign out_load  = (state_q == rhsm_pkg::S_DONE) && (!out_valid_q || m_axis_tready);

  // Control and hash state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rhsm_pkg::S_IDLE;
      plen_q      <= '0;
      ph_q        <= '0;
      lp_q        <= rhsm_pkg::hash_t'(1);
      wh_q        <= '0;
      filled_q    <= '0;
      tp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // Raise valid on a new result, drop it once taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        rhsm_pkg::S_IDLE: begin
          if (accept) begin
            unique case (act)
              rhsm_pkg::ACT_CLEAR: begin
                plen_q   <= '0;
                ph_q     <= '0;
                lp_q     <= rhsm_pkg::hash_t'(1);
                wh_q     <= '0;
                filled_q <= '0;
                tp_q     <= '0;
              end
              rhsm_pkg::ACT_PATTERN: begin
                if (!pat_full) begin
                  plen_q   <= plen_q + 1'b1;
                  wh_q     <= '0;
                  filled_q <= '0;
                  tp_q     <= '0;
                  state_q  <= rhsm_pkg::S_PPUSH;
                end
              end
              rhsm_pkg::ACT_RESTART: begin
                wh_q     <= '0;
                filled_q <= '0;
                tp_q     <= '0;
              end
              rhsm_pkg::ACT_TEXT: begin
                if (n_zero) begin
                  state_q <= rhsm_pkg::S_DONE;
                end else if (win_full) begin
                  state_q <= rhsm_pkg::S_DROP;
                end else begin
                  filled_q <= filled_q + 1'b1;
                  state_q  <= rhsm_pkg::S_TPUSH;
                end
              end
              default: begin
                state_q <= rhsm_pkg::S_IDLE;
              end
            endcase
          end
        end
        rhsm_pkg::S_DROP: begin
          if (mm_done) begin
            wh_q    <= h_after_drop;
            state_q <= rhsm_pkg::S_TPUSH;
          end
        end
        rhsm_pkg::S_TPUSH: begin
          if (mm_done) begin
            wh_q    <= pushed;
            state_q <= rhsm_pkg::S_DONE;
          end
        end
        rhsm_pkg::S_PPUSH: begin
          if (mm_done) begin
            ph_q    <= pushed;
            state_q <= (plen_q > LenW'(1)) ? rhsm_pkg::S_POWER : rhsm_pkg::S_IDLE;
          end
        end
        rhsm_pkg::S_POWER: begin
          if (mm_done) begin
            lp_q    <= mm_r;
            state_q <= rhsm_pkg::S_IDLE;
          end
        end
        rhsm_pkg::S_DONE: begin
          if (out_load) begin
            tp_q    <= tp_q + 32'd1;
            state_q <= rhsm_pkg::S_IDLE;
          end
        end
        default: begin
          state_q <= rhsm_pkg::S_IDLE;
        end
      endcase
    end
  end

  // Item payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      c_q   <= s_axis_tdata;
      old_q <= tail_char;
    end
    if (out_load) begin
      out_match_q <= hit;
      out_start_q <= hit ? start_pos : 32'd0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_start_q;
  assign m_axis_tuser  = out_match_q;

  // Checks
  `RHSM_ASSERT_ALWAYS(a_hash_range,
    (wh_q < rhsm_pkg::HashMod) && (ph_q < rhsm_pkg::HashMod) && (lp_q < rhsm_pkg::HashMod),
    "hash state out of modulus range")
  `RHSM_ASSERT_ALWAYS(a_fill_bound, filled_q <= plen_q, "window fill exceeds pattern length")
  `RHSM_ASSERT_IMPLY(a_mm_owner, mm_done,
    (state_q == rhsm_pkg::S_DROP) || (state_q == rhsm_pkg::S_TPUSH) ||
    (state_q == rhsm_pkg::S_PPUSH) || (state_q == rhsm_pkg::S_POWER),
    "multiply result with no consumer")
  `RHSM_ASSERT_IMPLY(a_miss_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 32'd0,
    "nonzero start on a miss")

endmodule
